// ----- hdl/handshaked_frame_sender_macros.svh -----
// Assertion helpers for the frame sender; clocked on i_clk, idle during reset.
`ifndef HANDSHAKED_FRAME_SENDER_MACROS_SVH
`define HANDSHAKED_FRAME_SENDER_MACROS_SVH

// Same-cycle implication.
`define HFS_ASSERT_IMPLY(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HFS_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/hfs_pkg.sv -----
package hfs_pkg;

    localparam int FRAME_COUNT   = 8;
    localparam int PAYLOAD_BYTES = 11;
    localparam int FRAME_BYTES   = 12;

    localparam int BYTE_W     = 8;
    localparam int FRAME_W    = 3;
    localparam int OFFSET_W   = 4;
    localparam int BNUM_W     = 4;
    localparam int GAP_W      = 16;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    localparam logic [GAP_W-1:0] GAP_RESET = 16'd300;

    // Program addresses. Emit sits at the top so that falling through wraps to fetch.
    typedef enum logic [3:0] {
        S_FETCH   = 4'd0,
        S_DISP    = 4'd1,
        S_WRAP    = 4'd2,
        S_WRAPDO  = 4'd3,
        S_ACTCHK  = 4'd4,
        S_CPYINIT = 4'd5,
        S_CPYLOOP = 4'd6,
        S_CPYEND  = 4'd7,
        S_GAPCHK  = 4'd8,
        S_RDYCHK  = 4'd9,
        S_XMIT    = 4'd10,
        S_GAP     = 4'd11,
        S_WRITE   = 4'd12,
        S_EMIT    = 4'd15
    } t_step;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_WRAP,
        OP_COPY_START,
        OP_COPY_BYTE,
        OP_FRAME_START,
        OP_SEND,
        OP_GAP,
        OP_WRITE,
        OP_EMIT
    } t_uop;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NONE,
        C_NO_INPUT,
        C_WRITE,
        C_NOT_END,
        C_ACTIVE,
        C_COPY_MORE,
        C_GAP,
        C_NOT_READY,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_step target;
    } t_cword;

    typedef struct packed {
        logic in_valid;
        logic is_write;
        logic ptr_end;
        logic active;
        logic copy_more;
        logic gap_pending;
        logic ready;
        logic out_busy;
    } t_status;

    // Control store: jump to target when cond holds, else step + 1.
    function automatic t_cword ucode(input t_step s);
        t_cword w;
        unique case (s)
            S_FETCH:   w = '{op: OP_LATCH,       cond: C_NO_INPUT,  target: S_FETCH};
            S_DISP:    w = '{op: OP_NONE,        cond: C_WRITE,     target: S_WRITE};
            S_WRAP:    w = '{op: OP_NONE,        cond: C_NOT_END,   target: S_ACTCHK};
            S_WRAPDO:  w = '{op: OP_WRAP,        cond: C_ALWAYS,    target: S_EMIT};
            S_ACTCHK:  w = '{op: OP_NONE,        cond: C_ACTIVE,    target: S_GAPCHK};
            S_CPYINIT: w = '{op: OP_COPY_START,  cond: C_NONE,      target: S_FETCH};
            S_CPYLOOP: w = '{op: OP_COPY_BYTE,   cond: C_COPY_MORE, target: S_CPYLOOP};
            S_CPYEND:  w = '{op: OP_FRAME_START, cond: C_NONE,      target: S_FETCH};
            S_GAPCHK:  w = '{op: OP_NONE,        cond: C_GAP,       target: S_GAP};
            S_RDYCHK:  w = '{op: OP_NONE,        cond: C_NOT_READY, target: S_EMIT};
            S_XMIT:    w = '{op: OP_SEND,        cond: C_ALWAYS,    target: S_EMIT};
            S_GAP:     w = '{op: OP_GAP,         cond: C_ALWAYS,    target: S_EMIT};
            S_WRITE:   w = '{op: OP_WRITE,       cond: C_ALWAYS,    target: S_EMIT};
            S_EMIT:    w = '{op: OP_EMIT,        cond: C_OUT_BUSY,  target: S_EMIT};
            default:   w = '{op: OP_NONE,        cond: C_ALWAYS,    target: S_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ----- hdl/hfs_ram.sv -----
module hfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 88
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/hfs_useq.sv -----
module hfs_useq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hfs_pkg::t_status i_status,
    output hfs_pkg::t_uop    o_op
);

    hfs_pkg::t_step  r_step;
    hfs_pkg::t_step  n_step;
    hfs_pkg::t_cword w_cw;
    logic            w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= hfs_pkg::S_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

    // next step
    always_comb begin
        w_cw = hfs_pkg::ucode(r_step);
        unique case (w_cw.cond)
            hfs_pkg::C_ALWAYS:    w_take = 1'b1;
            hfs_pkg::C_NONE:      w_take = 1'b0;
            hfs_pkg::C_NO_INPUT:  w_take = !i_status.in_valid;
            hfs_pkg::C_WRITE:     w_take = i_status.is_write;
            hfs_pkg::C_NOT_END:   w_take = !i_status.ptr_end;
            hfs_pkg::C_ACTIVE:    w_take = i_status.active;
            hfs_pkg::C_COPY_MORE: w_take = i_status.copy_more;
            hfs_pkg::C_GAP:       w_take = i_status.gap_pending;
            hfs_pkg::C_NOT_READY: w_take = !i_status.ready;
            hfs_pkg::C_OUT_BUSY:  w_take = i_status.out_busy;
            default:              w_take = 1'b0;
        endcase
        n_step = w_take ? w_cw.target : hfs_pkg::t_step'(r_step + 4'd1);
    end

    // control word out
    always_comb begin
        o_op = w_cw.op;
    end

endmodule

// ----- hdl/hfs_dpath.sv -----
module hfs_dpath #(
    parameter int FRAME_COUNT   = hfs_pkg::FRAME_COUNT,
    parameter int PAYLOAD_BYTES = hfs_pkg::PAYLOAD_BYTES,
    parameter int FRAME_BYTES   = hfs_pkg::FRAME_BYTES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hfs_pkg::t_uop                  i_op,
    output hfs_pkg::t_status               o_status,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [hfs_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [hfs_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic                           o_m_tuser,
    output logic                           o_m_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [hfs_pkg::GAP_W-1:0]      i_cfg_data
);

    localparam int DEPTH = FRAME_COUNT * PAYLOAD_BYTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AXW   = $clog2(DEPTH + PAYLOAD_BYTES + 1);
    localparam int FPW   = $clog2(FRAME_COUNT + 1);
    localparam int BPW   = $clog2(FRAME_BYTES);
    localparam int CIW   = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    localparam logic [CIW-1:0] RD_FIRST = (PAYLOAD_BYTES > 1) ? CIW'(1) : '0;
    localparam logic [CIW-1:0] CI_LAST  = CIW'(PAYLOAD_BYTES - 1);
    localparam logic [BPW-1:0] BP_LAST  = BPW'(FRAME_BYTES - 1);
    localparam logic [FPW-1:0] FP_END   = FPW'(FRAME_COUNT);

    localparam int BW = hfs_pkg::BYTE_W;

    // configuration and latched input item
    logic [hfs_pkg::GAP_W-1:0]    r_gap_ticks;
    logic                         r_in_write;
    logic                         r_in_ready;
    logic [hfs_pkg::FRAME_W-1:0]  r_in_frame;
    logic [hfs_pkg::OFFSET_W-1:0] r_in_offset;
    logic [BW-1:0]                r_in_value;

    // sender state
    logic [FPW-1:0]            r_frame_ptr;
    logic [BPW-1:0]            r_byte_ptr;
    logic                      r_active;
    logic                      r_gap_pending;
    logic [hfs_pkg::GAP_W-1:0] r_gap_cnt;
    logic [BW-1:0]             r_sum;
    logic [CIW-1:0]            r_rd_idx;
    logic [CIW-1:0]            r_wr_idx;
    logic [BW-1:0]             r_copy [PAYLOAD_BYTES];

    // staged result and output register
    logic                         r_res_valid;
    logic [BW-1:0]                r_res_byte;
    logic [hfs_pkg::FRAME_W-1:0]  r_res_frame;
    logic [hfs_pkg::BNUM_W-1:0]   r_res_bnum;
    logic                         r_res_done;
    logic                         r_m_tvalid;
    logic [hfs_pkg::M_TDATA_W-1:0] r_m_tdata;
    logic                         r_m_tuser;
    logic                         r_m_tlast;

    logic                      w_in_acc;
    logic                      w_out_busy;
    logic [AXW-1:0]            w_base;
    logic [AW-1:0]             w_rd_addr;
    logic [AW-1:0]             w_wr_addr;
    logic                      w_wr_ok;
    logic                      w_wr_en;
    logic [BW-1:0]             w_rd_data;
    logic                      w_in_payload;
    logic [CIW-1:0]            w_copy_idx;
    logic [BW-1:0]             w_send_byte;
    logic                      w_last;
    logic [hfs_pkg::GAP_W-1:0] w_gap_inc;
    logic                      w_gap_end;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (i_op == hfs_pkg::OP_LATCH);
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_out_busy  = r_m_tvalid && !i_m_tready;

    // table addressing: row base is frame * payload length
    assign w_base    = AXW'(r_frame_ptr) * AXW'(PAYLOAD_BYTES);
    assign w_rd_addr = AW'(w_base + ((i_op == hfs_pkg::OP_COPY_START) ? '0 : AXW'(r_rd_idx)));
    assign w_wr_addr = AW'(AXW'(r_in_frame) * AXW'(PAYLOAD_BYTES) + AXW'(r_in_offset));
    assign w_wr_ok   = (32'(r_in_frame) < FRAME_COUNT) && (32'(r_in_offset) < PAYLOAD_BYTES);
    assign w_wr_en   = (i_op == hfs_pkg::OP_WRITE) && w_wr_ok;

    hfs_ram #(
        .WIDTH (BW),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (r_in_value),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // positions past the payload carry the check byte
    assign w_in_payload = 32'(r_byte_ptr) < PAYLOAD_BYTES;
    assign w_copy_idx   = w_in_payload ? CIW'(r_byte_ptr) : '0;
    assign w_send_byte  = w_in_payload ? r_copy[w_copy_idx] : r_sum;
    assign w_last       = (r_byte_ptr == BP_LAST);

    assign w_gap_inc = (r_gap_cnt != '1) ? r_gap_cnt + 1'b1 : r_gap_cnt;
    assign w_gap_end = (w_gap_inc >= r_gap_ticks);

    always_comb begin
        o_status.in_valid    = i_s_tvalid;
        o_status.is_write    = r_in_write;
        o_status.ptr_end     = (r_frame_ptr >= FP_END);
        o_status.active      = r_active;
        o_status.copy_more   = (r_wr_idx != CI_LAST);
        o_status.gap_pending = r_gap_pending;
        o_status.ready       = r_in_ready;
        o_status.out_busy    = w_out_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_ticks   <= hfs_pkg::GAP_RESET;
            r_frame_ptr   <= '0;
            r_byte_ptr    <= '0;
            r_active      <= 1'b0;
            r_gap_pending <= 1'b0;
            r_gap_cnt     <= '0;
            r_sum         <= '0;
            r_rd_idx      <= '0;
            r_wr_idx      <= '0;
            r_m_tvalid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_gap_ticks <= i_cfg_data;
            end
            // a new result may load in the cycle the old one transfers
            if ((i_op == hfs_pkg::OP_EMIT) && !w_out_busy) begin
                r_m_tvalid <= 1'b1;
            end else if (r_m_tvalid && i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (i_op)
                hfs_pkg::OP_WRAP: begin
                    r_frame_ptr <= '0;
                end
                hfs_pkg::OP_COPY_START: begin
                    r_sum    <= '0;
                    r_rd_idx <= RD_FIRST;
                    r_wr_idx <= '0;
                end
                hfs_pkg::OP_COPY_BYTE: begin
                    r_sum    <= r_sum + w_rd_data;
                    r_wr_idx <= r_wr_idx + 1'b1;
                    if (r_rd_idx != CI_LAST) begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                end
                hfs_pkg::OP_FRAME_START: begin
                    r_active      <= 1'b1;
                    r_byte_ptr    <= '0;
                    r_gap_pending <= 1'b0;
                end
                hfs_pkg::OP_SEND: begin
                    r_gap_cnt     <= '0;
                    r_gap_pending <= 1'b1;
                    if (w_last) begin
                        r_active    <= 1'b0;
                        r_byte_ptr  <= '0;
                        r_frame_ptr <= r_frame_ptr + 1'b1;
                    end else begin
                        r_byte_ptr <= r_byte_ptr + 1'b1;
                    end
                end
                hfs_pkg::OP_GAP: begin
                    r_gap_cnt <= w_gap_inc;
                    if (w_gap_end) begin
                        r_gap_pending <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_write  <= i_s_tuser;
            r_in_ready  <= i_s_tdata[0];
            r_in_frame  <= i_s_tdata[3:1];
            r_in_offset <= i_s_tdata[7:4];
            r_in_value  <= i_s_tdata[15:8];
            r_res_valid <= 1'b0;
            r_res_byte  <= '0;
            r_res_frame <= '0;
            r_res_bnum  <= '0;
            r_res_done  <= 1'b0;
        end
        if (i_op == hfs_pkg::OP_COPY_BYTE) begin
            r_copy[r_wr_idx] <= w_rd_data;
        end
        if (i_op == hfs_pkg::OP_SEND) begin
            r_res_valid <= 1'b1;
            r_res_byte  <= w_send_byte;
            r_res_frame <= hfs_pkg::FRAME_W'(r_frame_ptr);
            r_res_bnum  <= hfs_pkg::BNUM_W'(r_byte_ptr);
            r_res_done  <= w_last;
        end
        if ((i_op == hfs_pkg::OP_EMIT) && !w_out_busy) begin
            r_m_tdata <= {1'b0, r_res_bnum, r_res_frame, r_res_byte};
            r_m_tuser <= r_res_valid;
            r_m_tlast <= r_res_done;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;
    assign o_m_tlast  = r_m_tlast;

endmodule

// ----- hdl/handshaked_frame_sender.sv -----
// channel  dir  transfer when               tuser          tdata (low bit up)
// s_axis   in   s_axis_tvalid & tready      action         ready, frame[3], offset[4], value[8]
// m_axis   out  m_axis_tvalid & tready      send_valid     byte[8], frame[3], byte_num[4], 0
// cfg      in   i_cfg_valid & o_cfg_ready   -              byte_gap_ticks[16]
//
// One item per pass of the microcode program; s_axis is ready only in the fetch step.
// Item kinds: table write, wrap tick, gap or ready-low tick, and sending tick, each ending in emit.
// A tick that opens a frame adds copy-init, the table-to-copy loop and copy-end, one byte
// per cycle through the single read port of the table RAM.
// The result waits in the m_axis register; only the emit step of the next item stalls on it.
// Reset is synchronous; the frame table is not cleared and needs writing before use.
`include "handshaked_frame_sender_macros.svh"

module handshaked_frame_sender #(
    parameter int FRAME_COUNT   = hfs_pkg::FRAME_COUNT,
    parameter int PAYLOAD_BYTES = hfs_pkg::PAYLOAD_BYTES,
    parameter int FRAME_BYTES   = hfs_pkg::FRAME_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [hfs_pkg::S_TDATA_W-1:0] s_axis_tdata,  // wait_ready, table_frame, table_offset, table_value
    input  logic                          s_axis_tuser,  // action
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [hfs_pkg::M_TDATA_W-1:0] m_axis_tdata,  // send_byte, frame_number, byte_number, pad
    output logic                          m_axis_tuser,  // send_valid
    output logic                          m_axis_tlast,  // frame_done
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hfs_pkg::GAP_W-1:0]     i_cfg_data
);

    hfs_pkg::t_uop    w_op;
    hfs_pkg::t_status w_status;

    hfs_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_op     (w_op)
    );

    hfs_dpath #(
        .FRAME_COUNT   (FRAME_COUNT),
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .FRAME_BYTES   (FRAME_BYTES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .o_status    (w_status),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .o_m_tlast   (m_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // frame end is always the check byte position of a sent byte
    `HFS_ASSERT_IMPLY(a_last_pos, m_axis_tvalid && m_axis_tlast, m_axis_tuser && (m_axis_tdata[14:11] == 4'(FRAME_BYTES - 1)), "frame end off the check byte")
    // one item in flight: no back-to-back accepts
    `HFS_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken twice in a row")
    // emit with a free output register must present the result
    `HFS_ASSERT_NEXT(a_emit_loads, (w_op == hfs_pkg::OP_EMIT) && !w_status.out_busy, m_axis_tvalid, "result not presented")

endmodule
